[design/obb_sat_pkg.sv]
// Shared widths, axis codes and pipeline types for the oriented box overlap test.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package obb_sat_pkg;

    // Field widths of one transaction.
    localparam int POS_W  = 24;   // signed Q15.8 center coordinate
    localparam int DIR_W  = 16;   // signed Q1.14 direction component
    localparam int EXT_W  = 23;   // unsigned Q15.8 full extent

    // Internal arithmetic widths; all arithmetic is exact.
    localparam int DIFF_W  = POS_W + 1;          // center difference
    localparam int DPROD_W = 2 * DIR_W;          // direction by direction product
    localparam int DDOT_W  = DPROD_W + 1;        // direction dot product
    localparam int DMAG_W  = DPROD_W;            // magnitude of a direction dot
    localparam int CPROD_W = DIFF_W + DIR_W;     // center difference by direction
    localparam int CDOT_W  = CPROD_W + 1;        // projected center distance
    localparam int CMAG_W  = CPROD_W;            // magnitude of that distance
    localparam int EPROD_W = DMAG_W + EXT_W;     // projected extent of the other box
    localparam int SUM_W   = EPROD_W + 2;        // compare width
    localparam int CTR_SHIFT = 15;               // center distance to the common scale
    localparam int OWN_SHIFT = 28;               // owner extent to the common scale

    localparam int NUM_AXES = 4;

    // Separating axis codes.
    localparam int AXIS_W = 3;
    localparam logic [AXIS_W-1:0] AXIS_A_RIGHT = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_A_UP    = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_B_RIGHT = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_B_UP    = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_NONE    = 3'd4;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_LAT = 7;

    // One registered box pair as it enters the projection stages.
    typedef struct packed {
        logic                     vld;
        logic signed [POS_W-1:0]  acx;
        logic signed [POS_W-1:0]  acy;
        logic signed [DIR_W-1:0]  arx;
        logic signed [DIR_W-1:0]  ary;
        logic [EXT_W-1:0]         aw;
        logic [EXT_W-1:0]         ah;
        logic signed [POS_W-1:0]  bcx;
        logic signed [POS_W-1:0]  bcy;
        logic signed [DIR_W-1:0]  brx;
        logic signed [DIR_W-1:0]  bry;
        logic [EXT_W-1:0]         bw;
        logic [EXT_W-1:0]         bh;
    } t_pair;

    // Projected magnitudes handed to the compare stages.
    typedef struct packed {
        logic                             vld;
        logic [NUM_AXES-1:0][CMAG_W-1:0]  ctr_mag;   // |d . n| per axis
        logic [DMAG_W-1:0]                cos_mag;   // |ra . rb|
        logic [DMAG_W-1:0]                sin_mag;   // |ra x rb|
        logic [EXT_W-1:0]                 aw;
        logic [EXT_W-1:0]                 ah;
        logic [EXT_W-1:0]                 bw;
        logic [EXT_W-1:0]                 bh;
    } t_proj;

endpackage

`default_nettype wire

[design/obb_sat_proj.sv]
// Projection stages of the oriented box overlap test: center difference, products
// and absolute dot products over three register stages. Depends on obb_sat_pkg.
`default_nettype none

module obb_sat_proj (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire obb_sat_pkg::t_pair  i_pair,
    output obb_sat_pkg::t_proj       o_proj
);
    import obb_sat_pkg::*;

    // Stage 2: center differences and direction products.
    logic                       r2_vld;
    logic signed [DIFF_W-1:0]   r2_dx, r2_dy;
    logic signed [DIR_W-1:0]    r2_arx, r2_ary, r2_brx, r2_bry;
    logic signed [DPROD_W-1:0]  r2_cc0, r2_cc1, r2_sc0, r2_sc1;
    logic [EXT_W-1:0]           r2_aw, r2_ah, r2_bw, r2_bh;

    // Stage 3: center products and direction dot magnitudes.
    logic                       r3_vld;
    logic signed [CPROD_W-1:0]  r3_prod [8];
    logic [DMAG_W-1:0]          r3_cos, r3_sin;
    logic [EXT_W-1:0]           r3_aw, r3_ah, r3_bw, r3_bh;

    // Stage 4: projected center distances.
    t_proj                      r4_proj;

    logic signed [DDOT_W-1:0]   n3_cos_dot, n3_sin_dot;
    logic signed [CDOT_W-1:0]   n4_dot [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= i_pair.vld;
        end
        r2_dx  <= DIFF_W'($signed(i_pair.bcx)) - DIFF_W'($signed(i_pair.acx));
        r2_dy  <= DIFF_W'($signed(i_pair.bcy)) - DIFF_W'($signed(i_pair.acy));
        r2_arx <= i_pair.arx;
        r2_ary <= i_pair.ary;
        r2_brx <= i_pair.brx;
        r2_bry <= i_pair.bry;
        r2_cc0 <= DPROD_W'($signed(i_pair.arx)) * DPROD_W'($signed(i_pair.brx));
        r2_cc1 <= DPROD_W'($signed(i_pair.ary)) * DPROD_W'($signed(i_pair.bry));
        r2_sc0 <= DPROD_W'($signed(i_pair.arx)) * DPROD_W'($signed(i_pair.bry));
        r2_sc1 <= DPROD_W'($signed(i_pair.ary)) * DPROD_W'($signed(i_pair.brx));
        r2_aw  <= i_pair.aw;
        r2_ah  <= i_pair.ah;
        r2_bw  <= i_pair.bw;
        r2_bh  <= i_pair.bh;
    end

    // The up vectors only flip signs, so two direction dots cover all four pairings.
    always_comb begin
        n3_cos_dot = DDOT_W'(r2_cc0) + DDOT_W'(r2_cc1);
        n3_sin_dot = DDOT_W'(r2_sc0) - DDOT_W'(r2_sc1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_prod[0] <= CPROD_W'(r2_dx) * CPROD_W'(r2_arx);
        r3_prod[1] <= CPROD_W'(r2_dy) * CPROD_W'(r2_ary);
        r3_prod[2] <= CPROD_W'(r2_dx) * CPROD_W'(r2_ary);
        r3_prod[3] <= CPROD_W'(r2_dy) * CPROD_W'(r2_arx);
        r3_prod[4] <= CPROD_W'(r2_dx) * CPROD_W'(r2_brx);
        r3_prod[5] <= CPROD_W'(r2_dy) * CPROD_W'(r2_bry);
        r3_prod[6] <= CPROD_W'(r2_dx) * CPROD_W'(r2_bry);
        r3_prod[7] <= CPROD_W'(r2_dy) * CPROD_W'(r2_brx);
        r3_cos <= n3_cos_dot[DDOT_W-1] ? DMAG_W'(-n3_cos_dot) : DMAG_W'(n3_cos_dot);
        r3_sin <= n3_sin_dot[DDOT_W-1] ? DMAG_W'(-n3_sin_dot) : DMAG_W'(n3_sin_dot);
        r3_aw  <= r2_aw;
        r3_ah  <= r2_ah;
        r3_bw  <= r2_bw;
        r3_bh  <= r2_bh;
    end

    // Up axis of a box is (-ry, rx), hence the differences on the odd axes.
    always_comb begin
        n4_dot[0] = CDOT_W'(r3_prod[0]) + CDOT_W'(r3_prod[1]);
        n4_dot[1] = CDOT_W'(r3_prod[3]) - CDOT_W'(r3_prod[2]);
        n4_dot[2] = CDOT_W'(r3_prod[4]) + CDOT_W'(r3_prod[5]);
        n4_dot[3] = CDOT_W'(r3_prod[7]) - CDOT_W'(r3_prod[6]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_proj.vld <= 1'b0;
        end else begin
            r4_proj.vld <= r3_vld;
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            r4_proj.ctr_mag[k] <= n4_dot[k][CDOT_W-1] ? CMAG_W'(-n4_dot[k])
                                                      : CMAG_W'(n4_dot[k]);
        end
        r4_proj.cos_mag <= r3_cos;
        r4_proj.sin_mag <= r3_sin;
        r4_proj.aw      <= r3_aw;
        r4_proj.ah      <= r3_ah;
        r4_proj.bw      <= r3_bw;
        r4_proj.bh      <= r3_bh;
    end

    assign o_proj = r4_proj;

endmodule

`default_nettype wire

[design/obb_sat_cmp.sv]
// Compare stages of the oriented box overlap test: extent products, limit sums and
// the per-axis separation compare with first-axis priority. Depends on obb_sat_pkg.
`default_nettype none

module obb_sat_cmp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire obb_sat_pkg::t_proj            i_proj,
    output logic                               o_valid,
    output logic                               o_overlap,
    output logic [obb_sat_pkg::AXIS_W-1:0]     o_separating_axis
);
    import obb_sat_pkg::*;

    // Stage 5: projected extents of the other box.
    logic                  r5_vld;
    logic [EPROD_W-1:0]    r5_pr  [NUM_AXES];
    logic [EPROD_W-1:0]    r5_pu  [NUM_AXES];
    logic [EXT_W-1:0]      r5_own [NUM_AXES];
    logic [CMAG_W-1:0]     r5_ctr [NUM_AXES];

    // Stage 6: separation limits.
    logic                  r6_vld;
    logic [SUM_W-1:0]      r6_lim [NUM_AXES];
    logic [CMAG_W-1:0]     r6_ctr [NUM_AXES];

    // Stage 7: result register.
    logic                  r7_vld;
    logic                  r7_overlap;
    logic [AXIS_W-1:0]     r7_axis;

    logic [NUM_AXES-1:0]   n7_sep;
    logic [AXIS_W-1:0]     n7_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= i_proj.vld;
        end
        // Box A axes see box B; box B axes see box A.
        r5_pr[0]  <= EPROD_W'(i_proj.cos_mag) * EPROD_W'(i_proj.bw);
        r5_pu[0]  <= EPROD_W'(i_proj.sin_mag) * EPROD_W'(i_proj.bh);
        r5_pr[1]  <= EPROD_W'(i_proj.sin_mag) * EPROD_W'(i_proj.bw);
        r5_pu[1]  <= EPROD_W'(i_proj.cos_mag) * EPROD_W'(i_proj.bh);
        r5_pr[2]  <= EPROD_W'(i_proj.cos_mag) * EPROD_W'(i_proj.aw);
        r5_pu[2]  <= EPROD_W'(i_proj.sin_mag) * EPROD_W'(i_proj.ah);
        r5_pr[3]  <= EPROD_W'(i_proj.sin_mag) * EPROD_W'(i_proj.aw);
        r5_pu[3]  <= EPROD_W'(i_proj.cos_mag) * EPROD_W'(i_proj.ah);
        r5_own[0] <= i_proj.aw;
        r5_own[1] <= i_proj.ah;
        r5_own[2] <= i_proj.bw;
        r5_own[3] <= i_proj.bh;
        for (int k = 0; k < NUM_AXES; k++) begin
            r5_ctr[k] <= i_proj.ctr_mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            r6_lim[k] <= SUM_W'(r5_pr[k]) + SUM_W'(r5_pu[k])
                       + SUM_W'({r5_own[k], OWN_SHIFT'(0)});
            r6_ctr[k] <= r5_ctr[k];
        end
    end

    // Strictly greater separates, so touching boxes overlap.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n7_sep[k] = SUM_W'({r6_ctr[k], CTR_SHIFT'(0)}) > r6_lim[k];
        end
        if (n7_sep[0]) begin
            n7_axis = AXIS_A_RIGHT;
        end else if (n7_sep[1]) begin
            n7_axis = AXIS_A_UP;
        end else if (n7_sep[2]) begin
            n7_axis = AXIS_B_RIGHT;
        end else if (n7_sep[3]) begin
            n7_axis = AXIS_B_UP;
        end else begin
            n7_axis = AXIS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_axis    <= n7_axis;
        r7_overlap <= ~|n7_sep;
    end

    assign o_valid           = r7_vld;
    assign o_overlap         = r7_overlap;
    assign o_separating_axis = r7_axis;

endmodule

`default_nettype wire

[design/oriented_box_overlap_test_top.sv]
// Top level of the oriented box overlap test (2D separating axis test on box axes).
// Depends on obb_sat_pkg, obb_sat_proj and obb_sat_cmp.
`default_nettype none

// Usage
//   Input channel: drive the two boxes on the i_a_* and i_b_* ports and raise start.
//   A transaction is taken at every rising edge where start is high and busy is low.
//   busy never rises, so a new box pair can be offered in every cycle.
//   Output channel: o_valid is high for exactly one cycle per input transaction,
//   with o_overlap and o_separating_axis valid in that cycle. Results leave in the
//   order the transactions came in.
//   Throughput is one box pair per cycle. The seven register stages are an input
//   register, three projection stages (center difference and direction products,
//   center products, absolute dot products) and three compare stages (extent
//   products, limit sums, compare and first-axis priority).
//   Reset: i_rst_n is synchronous and active low; it clears every stage valid bit,
//   so transactions in flight are dropped and no strobe follows reset.
//   Stall: the receiver cannot hold results off and no stage ever waits, so the
//   pipeline simply advances every cycle.
module oriented_box_overlap_test_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [obb_sat_pkg::POS_W-1:0]  i_a_center_x,
    input  wire logic signed [obb_sat_pkg::POS_W-1:0]  i_a_center_y,
    input  wire logic signed [obb_sat_pkg::DIR_W-1:0]  i_a_right_x,
    input  wire logic signed [obb_sat_pkg::DIR_W-1:0]  i_a_right_y,
    input  wire logic [obb_sat_pkg::EXT_W-1:0]         i_a_width,
    input  wire logic [obb_sat_pkg::EXT_W-1:0]         i_a_height,
    input  wire logic signed [obb_sat_pkg::POS_W-1:0]  i_b_center_x,
    input  wire logic signed [obb_sat_pkg::POS_W-1:0]  i_b_center_y,
    input  wire logic signed [obb_sat_pkg::DIR_W-1:0]  i_b_right_x,
    input  wire logic signed [obb_sat_pkg::DIR_W-1:0]  i_b_right_y,
    input  wire logic [obb_sat_pkg::EXT_W-1:0]         i_b_width,
    input  wire logic [obb_sat_pkg::EXT_W-1:0]         i_b_height,
    output logic                                       o_valid,
    output logic                                       o_overlap,
    output logic [obb_sat_pkg::AXIS_W-1:0]             o_separating_axis
);
    import obb_sat_pkg::*;

    // Stage 1: the accepted transaction is registered as it stands.
    t_pair r1_pair;
    t_proj w_proj;

    // The pipeline never stalls, so the input side is always open.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_pair.vld <= 1'b0;
        end else begin
            r1_pair.vld <= start & ~busy;
        end
        r1_pair.acx <= i_a_center_x;
        r1_pair.acy <= i_a_center_y;
        r1_pair.arx <= i_a_right_x;
        r1_pair.ary <= i_a_right_y;
        r1_pair.aw  <= i_a_width;
        r1_pair.ah  <= i_a_height;
        r1_pair.bcx <= i_b_center_x;
        r1_pair.bcy <= i_b_center_y;
        r1_pair.brx <= i_b_right_x;
        r1_pair.bry <= i_b_right_y;
        r1_pair.bw  <= i_b_width;
        r1_pair.bh  <= i_b_height;
    end

    // Stages 2 to 4: projections of the center distance and of the box directions.
    obb_sat_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (r1_pair),
        .o_proj  (w_proj)
    );

    // Stages 5 to 7: extent products, limits, compare and first-axis priority.
    obb_sat_cmp u_cmp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_proj            (w_proj),
        .o_valid           (o_valid),
        .o_overlap         (o_overlap),
        .o_separating_axis (o_separating_axis)
    );

    // The overlap flag and the axis code must agree on every result.
    a_overlap_matches_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_overlap == (o_separating_axis == AXIS_NONE)))
        else $error("overlap flag disagrees with separating axis code");

    // Every accepted transaction yields a result after the fixed latency.
    a_result_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a transaction accepted the latency before.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, PIPE_LAT))
        else $error("result strobe without an accepted transaction");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for oriented_box_overlap_test_top, the 2D separating axis test.
// Depends on obb_sat_pkg for widths and axis codes; it predicts every result on its own
// and drives directed corner cases first, then random box pairs under varying sender gaps.

module testbench;
    import obb_sat_pkg::*;

    // Q15.8 one and the Q1.14 unit and 45 degree direction components.
    localparam int ONE  = 256;
    localparam int UNIT = 16384;
    localparam int DIAG = 11585;

    // The run ends with a failure if it is still going after this many cycles. The limit
    // leaves a wide margin for long sender gaps.
    localparam int CYCLE_LIMIT = 200000;

    // One transaction: both boxes at the port widths.
    typedef struct packed {
        logic signed [POS_W-1:0] acx;
        logic signed [POS_W-1:0] acy;
        logic signed [DIR_W-1:0] arx;
        logic signed [DIR_W-1:0] ary;
        logic [EXT_W-1:0]        aw;
        logic [EXT_W-1:0]        ah;
        logic signed [POS_W-1:0] bcx;
        logic signed [POS_W-1:0] bcy;
        logic signed [DIR_W-1:0] brx;
        logic signed [DIR_W-1:0] bry;
        logic [EXT_W-1:0]        bw;
        logic [EXT_W-1:0]        bh;
    } t_box_pair;

    // What the block should report for one box pair.
    typedef struct packed {
        logic              overlap;
        logic [AXIS_W-1:0] axis;
    } t_overlap_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [POS_W-1:0] i_a_center_x;
    logic signed [POS_W-1:0] i_a_center_y;
    logic signed [DIR_W-1:0] i_a_right_x;
    logic signed [DIR_W-1:0] i_a_right_y;
    logic [EXT_W-1:0]        i_a_width;
    logic [EXT_W-1:0]        i_a_height;
    logic signed [POS_W-1:0] i_b_center_x;
    logic signed [POS_W-1:0] i_b_center_y;
    logic signed [DIR_W-1:0] i_b_right_x;
    logic signed [DIR_W-1:0] i_b_right_y;
    logic [EXT_W-1:0]        i_b_width;
    logic [EXT_W-1:0]        i_b_height;
    logic                    o_valid;
    logic                    o_overlap;
    logic [AXIS_W-1:0]       o_separating_axis;

    // Results the block still owes, oldest first.
    t_overlap_result pending_results[$];
    t_overlap_result got_result;
    t_overlap_result want_result;

    int sender_idle_pct;
    int pairs_accepted;
    int results_checked;
    int mismatch_count;
    int cycle_count;
    int axis_count[0:4];

    oriented_box_overlap_test_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_a_center_x      (i_a_center_x),
        .i_a_center_y      (i_a_center_y),
        .i_a_right_x       (i_a_right_x),
        .i_a_right_y       (i_a_right_y),
        .i_a_width         (i_a_width),
        .i_a_height        (i_a_height),
        .i_b_center_x      (i_b_center_x),
        .i_b_center_y      (i_b_center_y),
        .i_b_right_x       (i_b_right_x),
        .i_b_right_y       (i_b_right_y),
        .i_b_width         (i_b_width),
        .i_b_height        (i_b_height),
        .o_valid           (o_valid),
        .o_overlap         (o_overlap),
        .o_separating_axis (o_separating_axis)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Free-running cycle counter that doubles as the watchdog for a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------------------

    // True when axis n separates the boxes. Everything is compared on doubled values at a
    // scale of 2^-36: the center distance is Q.22 after the product, so it is shifted up by
    // 15 (14 to the common scale, one for the doubling). The other box's full extents times
    // its projected directions land on 2^-36 directly, and the owning box's full extent is
    // shifted up by 28. A strict greater-than means touching boxes do not separate.
    function automatic logic axis_separates(input longint dx, input longint dy,
                                            input longint nx, input longint ny,
                                            input longint own_ext,
                                            input longint orx, input longint ory,
                                            input longint ow, input longint oh);
        longint ctr_dist;
        longint right_proj;
        longint up_proj;
        ctr_dist   = dx * nx + dy * ny;
        right_proj = orx * nx + ory * ny;
        up_proj    = -ory * nx + orx * ny;
        if (ctr_dist < 0) ctr_dist = -ctr_dist;
        if (right_proj < 0) right_proj = -right_proj;
        if (up_proj < 0) up_proj = -up_proj;
        return (ctr_dist <<< 15) > (right_proj * ow + up_proj * oh + (own_ext <<< 28));
    endfunction

    // Runs the four axis tests in priority order: A right, A up, B right, B up. The up
    // vector is the right vector turned by +90 degrees, (-ry, rx). Directions are used as
    // given, so a zero or over-long vector and the -2.0 pattern all go through unchanged.
    function automatic t_overlap_result predict_overlap(input t_box_pair p);
        t_overlap_result r;
        longint dx, dy;
        longint arx, ary, brx, bry;
        longint aw, ah, bw, bh;
        dx  = longint'(p.bcx) - longint'(p.acx);
        dy  = longint'(p.bcy) - longint'(p.acy);
        arx = longint'(p.arx);
        ary = longint'(p.ary);
        brx = longint'(p.brx);
        bry = longint'(p.bry);
        aw  = longint'(p.aw);
        ah  = longint'(p.ah);
        bw  = longint'(p.bw);
        bh  = longint'(p.bh);
        if (axis_separates(dx, dy, arx, ary, aw, brx, bry, bw, bh))
            r.axis = AXIS_A_RIGHT;
        else if (axis_separates(dx, dy, -ary, arx, ah, brx, bry, bw, bh))
            r.axis = AXIS_A_UP;
        else if (axis_separates(dx, dy, brx, bry, bw, arx, ary, aw, ah))
            r.axis = AXIS_B_RIGHT;
        else if (axis_separates(dx, dy, -bry, brx, bh, arx, ary, aw, ah))
            r.axis = AXIS_B_UP;
        else
            r.axis = AXIS_NONE;
        r.overlap = (r.axis == AXIS_NONE);
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] mismatch: %s", cycle_count, what);
    endtask

    // One process watches both channels at the rising edge. The result side is checked
    // first and the input side predicted second, so the order within the edge is fixed no
    // matter how the simulator schedules the driver. Reset drops anything in flight, but
    // reset is only asserted before the first transaction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid !== 1'b0) begin
                got_result.overlap = o_overlap;
                got_result.axis    = o_separating_axis;
                if (o_valid !== 1'b1) begin
                    report_mismatch("result strobe is unknown");
                end else if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result overlap=%b axis=%0d",
                                              o_overlap, o_separating_axis));
                end else begin
                    want_result = pending_results.pop_front();
                    results_checked++;
                    if (got_result.overlap !== want_result.overlap)
                        report_mismatch($sformatf("result %0d overlap got %b want %b",
                                                  results_checked, got_result.overlap,
                                                  want_result.overlap));
                    if (got_result.axis !== want_result.axis)
                        report_mismatch($sformatf("result %0d axis got %0d want %0d",
                                                  results_checked, got_result.axis,
                                                  want_result.axis));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                want_result = predict_overlap('{i_a_center_x, i_a_center_y, i_a_right_x,
                                                i_a_right_y, i_a_width, i_a_height,
                                                i_b_center_x, i_b_center_y, i_b_right_x,
                                                i_b_right_y, i_b_width, i_b_height});
                pending_results.push_back(want_result);
                axis_count[want_result.axis]++;
                pairs_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------------------

    function automatic t_box_pair make_pair(input int acx, input int acy, input int arx,
                                            input int ary, input int aw, input int ah,
                                            input int bcx, input int bcy, input int brx,
                                            input int bry, input int bw, input int bh);
        t_box_pair p;
        p.acx = POS_W'(acx);  p.acy = POS_W'(acy);
        p.arx = DIR_W'(arx);  p.ary = DIR_W'(ary);
        p.aw  = EXT_W'(aw);   p.ah  = EXT_W'(ah);
        p.bcx = POS_W'(bcx);  p.bcy = POS_W'(bcy);
        p.brx = DIR_W'(brx);  p.bry = DIR_W'(bry);
        p.bw  = EXT_W'(bw);   p.bh  = EXT_W'(bh);
        return p;
    endfunction

    // Offers one transaction. Called at a falling edge and returns at a falling edge. Before
    // driving, the sender may sit idle for a while depending on the current phase; start
    // stays high between back-to-back transactions and is written once per falling edge.
    task automatic send_pair(input t_box_pair p);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_a_center_x = p.acx;
        i_a_center_y = p.acy;
        i_a_right_x  = p.arx;
        i_a_right_y  = p.ary;
        i_a_width    = p.aw;
        i_a_height   = p.ah;
        i_b_center_x = p.bcx;
        i_b_center_y = p.bcy;
        i_b_right_x  = p.brx;
        i_b_right_y  = p.bry;
        i_b_width    = p.bw;
        i_b_height   = p.bh;
        start        = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random box pair. Most pairs are real rectangles with unit-length directions placed
    // close enough that any axis may decide; some are axis-aligned pairs placed right at
    // the touching distance; the rest are raw bit patterns over every field.
    function automatic t_box_pair random_pair();
        t_box_pair    p;
        logic [255:0] raw_bits;
        int  kind;
        int  a_xh, a_yh, b_xh, b_yh;
        int  reach, span;
        real ang;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            raw_bits = {$urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom()};
            p = raw_bits[$bits(t_box_pair)-1:0];
        end else if (kind < 40) begin
            // Cardinal directions with even extents, so the half extents are exact and the
            // center offset can land on, just inside or just outside the touching distance.
            p.acx = POS_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            p.acy = POS_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            p.aw  = EXT_W'(2 * $urandom_range(0, 4096));
            p.ah  = EXT_W'(2 * $urandom_range(0, 4096));
            p.bw  = EXT_W'(2 * $urandom_range(0, 4096));
            p.bh  = EXT_W'(2 * $urandom_range(0, 4096));
            case ($urandom_range(0, 3))
                0: begin p.arx = DIR_W'(UNIT);  p.ary = '0;            end
                1: begin p.arx = '0;            p.ary = DIR_W'(UNIT);  end
                2: begin p.arx = DIR_W'(-UNIT); p.ary = '0;            end
                default: begin p.arx = '0; p.ary = DIR_W'(-UNIT); end
            endcase
            case ($urandom_range(0, 3))
                0: begin p.brx = DIR_W'(UNIT);  p.bry = '0;            end
                1: begin p.brx = '0;            p.bry = DIR_W'(UNIT);  end
                2: begin p.brx = DIR_W'(-UNIT); p.bry = '0;            end
                default: begin p.brx = '0; p.bry = DIR_W'(-UNIT); end
            endcase
            a_xh = (p.arx != 0) ? int'(p.aw) / 2 : int'(p.ah) / 2;
            a_yh = (p.arx != 0) ? int'(p.ah) / 2 : int'(p.aw) / 2;
            b_xh = (p.brx != 0) ? int'(p.bw) / 2 : int'(p.bh) / 2;
            b_yh = (p.brx != 0) ? int'(p.bh) / 2 : int'(p.bw) / 2;
            if ($urandom_range(0, 1)) begin
                span  = a_yh + b_yh + 2;
                p.bcx = POS_W'(int'(p.acx) + ($urandom_range(0, 1) ? 1 : -1) * (a_xh + b_xh)
                               + int'($urandom_range(0, 4)) - 2);
                p.bcy = POS_W'(int'(p.acy) + int'($urandom_range(0, 2 * span)) - span);
            end else begin
                span  = a_xh + b_xh + 2;
                p.bcy = POS_W'(int'(p.acy) + ($urandom_range(0, 1) ? 1 : -1) * (a_yh + b_yh)
                               + int'($urandom_range(0, 4)) - 2);
                p.bcx = POS_W'(int'(p.acx) + int'($urandom_range(0, 2 * span)) - span);
            end
        end else begin
            ang   = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            p.arx = DIR_W'($rtoi(16384.0 * $cos(ang)));
            p.ary = DIR_W'($rtoi(16384.0 * $sin(ang)));
            ang   = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            p.brx = DIR_W'($rtoi(16384.0 * $cos(ang)));
            p.bry = DIR_W'($rtoi(16384.0 * $sin(ang)));
            // Mostly modest sizes, now and then up to the full extent range.
            p.aw  = EXT_W'($urandom_range(0, (1 << $urandom_range(4, 14)) - 1));
            p.ah  = EXT_W'($urandom_range(0, (1 << $urandom_range(4, 14)) - 1));
            p.bw  = EXT_W'($urandom_range(0, (1 << $urandom_range(4, 14)) - 1));
            p.bh  = EXT_W'($urandom_range(0, (1 << $urandom_range(4, 14)) - 1));
            if ($urandom_range(0, 19) == 0) begin
                p.aw = EXT_W'($urandom_range(0, (1 << 23) - 1));
                p.bh = EXT_W'($urandom_range(0, (1 << 23) - 1));
            end
            if ($urandom_range(0, 9) == 0) begin
                p.acx = POS_W'($urandom());
                p.acy = POS_W'($urandom());
            end else begin
                p.acx = POS_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
                p.acy = POS_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            end
            // Scatter B over a square about as wide as both boxes reach, so that roughly
            // half the pairs overlap and every axis gets to be the separating one.
            reach = (int'(p.aw) + int'(p.ah) + int'(p.bw) + int'(p.bh)) * 5 / 8 + 1;
            p.bcx = POS_W'(int'(p.acx) + int'($urandom_range(0, 2 * reach)) - reach);
            p.bcy = POS_W'(int'(p.acy) + int'($urandom_range(0, 2 * reach)) - reach);
        end
        return p;
    endfunction

    // Axis-aligned squares (2 x 2, with a 1 x 1 B in the last pair): apart along x, apart along y, and overlapping.
    task automatic test_axis_aligned_pairs();
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            100 * ONE, 0, UNIT, 0, 2 * ONE, 2 * ONE));
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            0, 100 * ONE, UNIT, 0, 2 * ONE, 2 * ONE));
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            ONE, ONE, UNIT, 0, ONE, ONE));
    endtask

    // A 45 degree square next to a corner of an aligned square: only B's own axes split
    // them, the right one for the diagonal corner and the up one for the other diagonal.
    task automatic test_rotated_box_axes();
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            3 * ONE / 2, 3 * ONE / 2, DIAG, DIAG, ONE, ONE));
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            3 * ONE / 2, -3 * ONE / 2, DIAG, DIAG, ONE, ONE));
        // Roles swapped: the rotated box is A, so its own axis must win.
        send_pair(make_pair(3 * ONE / 2, 3 * ONE / 2, DIAG, DIAG, ONE, ONE,
                            0, 0, UNIT, 0, 2 * ONE, 2 * ONE));
    endtask

    // Boxes that touch count as overlapping; one step further apart separates them.
    task automatic test_touching_boxes();
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            2 * ONE, 0, UNIT, 0, 2 * ONE, 2 * ONE));
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            2 * ONE + 1, 0, UNIT, 0, 2 * ONE, 2 * ONE));
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            0, 2 * ONE, -UNIT, 0, 2 * ONE, 2 * ONE));
        send_pair(make_pair(0, 0, UNIT, 0, 2 * ONE, 2 * ONE,
                            0, -2 * ONE - 1, 0, UNIT, 2 * ONE, 2 * ONE));
        // Zero-size boxes on one point touch; one step apart they do not.
        send_pair(make_pair(5, 7, UNIT, 0, 0, 0, 5, 7, 0, UNIT, 0, 0));
        send_pair(make_pair(5, 7, UNIT, 0, 0, 0, 6, 7, 0, UNIT, 0, 0));
    endtask

    // Directions that are not unit length: zero vectors project everything to nothing,
    // the most negative pattern means -2.0, and over-long vectors are taken as given.
    task automatic test_non_unit_directions();
        send_pair(make_pair(0, 0, 0, 0, 100, 200, 5000 * ONE, -3000 * ONE, 0, 0, 300, 400));
        send_pair(make_pair(0, 0, -32768, 0, 4 * ONE, 2 * ONE,
                            5 * ONE, ONE, 0, -32768, 2 * ONE, 2 * ONE));
        send_pair(make_pair(ONE, -ONE, 32767, -32768, 3 * ONE, ONE,
                            -4 * ONE, 2 * ONE, -32768, 32767, ONE, 5 * ONE));
        send_pair(make_pair(0, 0, 2 * DIAG, -DIAG, 8 * ONE, ONE,
                            6 * ONE, 3 * ONE, UNIT / 2, UNIT / 3, 2 * ONE, 7 * ONE));
    endtask

    // Field extremes: opposite corners of the coordinate range, full extents, and the
    // largest and smallest direction patterns, to exercise the widest intermediate values.
    task automatic test_field_extremes();
        send_pair(make_pair(-8388608, -8388608, -32768, -32768, 8388607, 8388607,
                            8388607, 8388607, -32768, -32768, 8388607, 8388607));
        send_pair(make_pair(8388607, 8388607, UNIT, -UNIT, 8388607, 0,
                            -8388608, -8388608, -UNIT, UNIT, 0, 8388607));
        send_pair(make_pair(0, 0, 32767, 32767, 8388607, 8388607,
                            0, 0, 32767, -32768, 8388607, 8388607));
        send_pair(make_pair(8388607, 8388607, 32767, 32767, 8388607, 8388607,
                            8388607, 8388607, 32767, 32767, 8388607, 8388607));
        send_pair(make_pair(-8388608, -8388608, -32768, -32768, 0, 0,
                            8388607, -8388608, -32768, -32768, 0, 0));
        send_pair(make_pair(-8388608, 8388607, UNIT, 0, 0, 0,
                            8388607, -8388608, 0, -UNIT, 0, 0));
    endtask

    // A stretch of random pairs with the sender idle the given percentage of the time.
    task automatic test_random_traffic(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count) send_pair(random_pair());
        sender_idle_pct = 0;
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------------------

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_a_center_x    = '0;
        i_a_center_y    = '0;
        i_a_right_x     = '0;
        i_a_right_y     = '0;
        i_a_width       = '0;
        i_a_height      = '0;
        i_b_center_x    = '0;
        i_b_center_y    = '0;
        i_b_right_x     = '0;
        i_b_right_y     = '0;
        i_b_width       = '0;
        i_b_height      = '0;
        sender_idle_pct = 0;
        pairs_accepted  = 0;
        results_checked = 0;
        mismatch_count  = 0;
        for (int i = 0; i < 5; i++) axis_count[i] = 0;

        // Synchronous reset held low from the start, released on a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pairs go back to back so they also fill the pipeline.
        test_axis_aligned_pairs();
        test_rotated_box_axes();
        test_touching_boxes();
        test_non_unit_directions();
        test_field_extremes();

        // Random phases: a full-rate stream, a mostly idle sender, a second full-rate
        // stream, and light gaps. The block never holds results off, so there is no
        // receiver stall to mix in.
        test_random_traffic(420, 0);
        test_random_traffic(420, 87);
        test_random_traffic(400, 0);
        test_random_traffic(420, 22);

        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Quiet period: any strobe here has no expectation and is flagged by the checker.
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d box pairs over %0d cycles, %0d results checked, %0d mismatches",
                 pairs_accepted, cycle_count, results_checked, mismatch_count);
        $display("first separating axis: A right %0d, A up %0d, B right %0d, B up %0d, none %0d",
                 axis_count[0], axis_count[1], axis_count[2], axis_count[3], axis_count[4]);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
